// File: src/srpe_pkg.sv
// Shared types, codes and the axis bound function of the sphere region peak evaluator.
package srpe_pkg;

   localparam int GRID_CELLS_DEF = 32768;
   localparam int SIZE_W         = 6;
   localparam int VALUE_W        = 16;
   localparam int DEPTH_W        = 4;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 16;
   localparam int BOX_ADDR_W     = 18;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_X      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_Y      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_Z      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPLIT_LEVEL = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_LIMIT = 3'd4;

   typedef struct packed {
      logic                opcode;
      logic [14:0]         cell_index;
      logic [VALUE_W-1:0]  cell_value;
      logic [15:0]         center_x;
      logic [15:0]         center_y;
      logic [15:0]         center_z;
      logic [15:0]         sphere_radius;
      logic [DEPTH_W-1:0]  tree_depth;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] peak_pressure;
      logic               wants_split;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  size_x;
      logic [SIZE_W-1:0]  size_y;
      logic [SIZE_W-1:0]  size_z;
      logic [VALUE_W-1:0] split_level;
      logic [DEPTH_W-1:0] depth_limit;
   } cfg_type;

   typedef struct packed {
      logic       clr_step;
      logic       wr_en;
      logic       capture;
      logic       setup_step;
      logic [1:0] setup_axis;
      logic       scan_init;
      logic       scan_step;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic box_empty;
      logic scan_last;
   } status_type;

   typedef struct packed {
      logic              empty;
      logic [SIZE_W-1:0] lo;
      logic [SIZE_W-1:0] hi;
   } span_type;

   // Inclusive voxel bounds of one axis, clamped to the grid.
   function automatic span_type axis_bounds(input logic [15:0] c, input logic [15:0] r,
                                            input logic [SIZE_W-1:0] dim);
      logic signed [16:0] diff;
      logic signed [23:0] lprod;
      logic [16:0]        sum;
      logic [22:0]        hprod;
      logic [6:0]         high;
      logic [5:0]         low;
      logic [5:0]         top;
      span_type           s;
      diff  = $signed({1'b0, c}) - $signed({1'b0, r});
      lprod = 24'(diff) * $signed({18'd0, dim});
      low   = lprod[23] ? 6'd0 : lprod[21:16];
      sum   = {1'b0, c} + {1'b0, r};
      hprod = 23'(sum) * 23'(dim);
      high  = hprod[22:16];
      top   = dim - 6'd1;
      if (high > {1'b0, top}) begin
         high = {1'b0, top};
      end
      s.empty = (dim == 6'd0) || ({1'b0, low} > high);
      s.lo    = low;
      s.hi    = high[5:0];
      return s;
   endfunction

endpackage

// File: src/srpe_ctrl.sv
// Controller state machine that sequences clearing, writes, box setup, scan and result hand-off.
module srpe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_opcode,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  srpe_pkg::status_type   status,
   output srpe_pkg::cmd_type      cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_SETUP  = 7'b0000100,
      ST_INIT   = 7'b0001000,
      ST_SCAN   = 7'b0010000,
      ST_DRAIN  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in       = state_ff;
      axis_in        = axis_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == srpe_pkg::OP_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  axis_in     = srpe_pkg::AXIS_X;
                  state_in    = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup_step = 1'b1;
            cmd.setup_axis = axis_ff;
            axis_in        = axis_ff + 2'd1;
            if (axis_ff == srpe_pkg::AXIS_Z) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.scan_init = 1'b1;
            state_in      = status.box_empty ? ST_FINISH : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         axis_ff      <= srpe_pkg::AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/srpe_dp.sv
// Datapath with the pressure grid memory, box bound registers, scan counters and peak register.
module srpe_dp #(
   parameter int GRID_CELLS = srpe_pkg::GRID_CELLS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  srpe_pkg::cmd_type     cmd,
   input  srpe_pkg::req_type     req_data,
   input  srpe_pkg::cfg_type     cfg,
   output srpe_pkg::status_type  status,
   output srpe_pkg::rsp_type     rsp_data
);

   localparam int AW     = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
   localparam int SCAN_W = (AW + 1 > srpe_pkg::BOX_ADDR_W) ? AW + 1 : srpe_pkg::BOX_ADDR_W;
   localparam int SW     = srpe_pkg::SIZE_W;

   logic [srpe_pkg::VALUE_W-1:0] mem [GRID_CELLS];

   logic [AW-1:0]                clr_cnt_ff;
   logic                         rd_valid_ff;
   logic [srpe_pkg::VALUE_W-1:0] rd_data_ff;
   logic [srpe_pkg::VALUE_W-1:0] peak_ff;
   logic [15:0]                  cx_ff, cy_ff, cz_ff, rad_ff;
   logic [srpe_pkg::DEPTH_W-1:0] depth_ff;
   srpe_pkg::span_type           span_x_ff, span_y_ff, span_z_ff;
   logic                         empty_ff;
   logic [2*SW-1:0]              sxy_ff;
   logic [SW-1:0]                x_ff, y_ff, z_ff;
   logic [SCAN_W-1:0]            plane_ff, row_ff, row_first_ff;
   srpe_pkg::rsp_type            rsp_ff;

   logic [15:0]                  sel_c;
   logic [SW-1:0]                sel_dim;
   srpe_pkg::span_type           span;
   logic [SCAN_W-1:0]            scan_addr;
   logic                         scan_in_range;
   logic [SCAN_W-1:0]            wr_addr;
   logic                         mem_we;
   logic [AW-1:0]                mem_wa;
   logic [srpe_pkg::VALUE_W-1:0] mem_wd;
   logic                         x_end, y_end, z_end;

   always_comb begin
      case (cmd.setup_axis)
         srpe_pkg::AXIS_X: begin
            sel_c   = cx_ff;
            sel_dim = cfg.size_x;
         end
         srpe_pkg::AXIS_Y: begin
            sel_c   = cy_ff;
            sel_dim = cfg.size_y;
         end
         default: begin
            sel_c   = cz_ff;
            sel_dim = cfg.size_z;
         end
      endcase
   end

   assign span = srpe_pkg::axis_bounds(sel_c, rad_ff, sel_dim);

   assign scan_addr     = plane_ff + row_ff + SCAN_W'(x_ff);
   assign scan_in_range = 32'(scan_addr) < 32'(GRID_CELLS);
   assign wr_addr       = SCAN_W'(req_data.cell_index);
   assign mem_we        = cmd.clr_step | (cmd.wr_en & (32'(wr_addr) < 32'(GRID_CELLS)));
   assign mem_wa        = cmd.clr_step ? clr_cnt_ff : wr_addr[AW-1:0];
   assign mem_wd        = cmd.clr_step ? '0 : req_data.cell_value;

   assign x_end = (x_ff == span_x_ff.hi);
   assign y_end = (y_ff == span_y_ff.hi);
   assign z_end = (z_ff == span_z_ff.hi);

   assign status.clr_last  = (clr_cnt_ff == AW'(GRID_CELLS - 1));
   assign status.box_empty = empty_ff;
   assign status.scan_last = x_end & y_end & z_end;
   assign rsp_data         = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[scan_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         rd_valid_ff <= cmd.scan_step & scan_in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cx_ff    <= req_data.center_x;
         cy_ff    <= req_data.center_y;
         cz_ff    <= req_data.center_z;
         rad_ff   <= req_data.sphere_radius;
         depth_ff <= req_data.tree_depth;
         empty_ff <= 1'b0;
      end
      if (cmd.setup_step) begin
         empty_ff <= empty_ff | span.empty;
         case (cmd.setup_axis)
            srpe_pkg::AXIS_X: begin
               span_x_ff <= span;
               sxy_ff    <= (2*SW)'(cfg.size_x) * (2*SW)'(cfg.size_y);
            end
            srpe_pkg::AXIS_Y: span_y_ff <= span;
            default:          span_z_ff <= span;
         endcase
      end
      if (cmd.scan_init) begin
         x_ff         <= span_x_ff.lo;
         y_ff         <= span_y_ff.lo;
         z_ff         <= span_z_ff.lo;
         plane_ff     <= SCAN_W'(span_z_ff.lo) * SCAN_W'(sxy_ff);
         row_ff       <= SCAN_W'(span_y_ff.lo) * SCAN_W'(cfg.size_x);
         row_first_ff <= SCAN_W'(span_y_ff.lo) * SCAN_W'(cfg.size_x);
         peak_ff      <= '0;
      end else begin
         if (rd_valid_ff && (rd_data_ff > peak_ff)) begin
            peak_ff <= rd_data_ff;
         end
         if (cmd.scan_step) begin
            if (!x_end) begin
               x_ff <= x_ff + SW'(1);
            end else begin
               x_ff <= span_x_ff.lo;
               if (!y_end) begin
                  y_ff   <= y_ff + SW'(1);
                  row_ff <= row_ff + SCAN_W'(cfg.size_x);
               end else begin
                  y_ff     <= span_y_ff.lo;
                  row_ff   <= row_first_ff;
                  z_ff     <= z_ff + SW'(1);
                  plane_ff <= plane_ff + SCAN_W'(sxy_ff);
               end
            end
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.peak_pressure <= peak_ff;
         rsp_ff.wants_split   <= (peak_ff > cfg.split_level) && (depth_ff < cfg.depth_limit);
      end
   end

endmodule

// File: src/sphere_region_peak_evaluator_top.sv
// Top level of the sphere region peak evaluator: configuration registers, controller and datapath.
//
// After reset the block clears its grid memory, one cell a cycle, and accepts no word until that
// pass ends; configuration writes are taken throughout. A write word stores one cell and the next
// word may follow at once. An evaluate word forms the voxel box one axis at a time, X, Y then Z,
// in the setup state, loads the scan in the init state, then reads the box one cell a cycle,
// since the grid memory has a single read port, and drains the last read before the finish state
// hands the result to the output register; an empty box goes from init straight to finish.
// A finished result waits in the output register while the next word is accepted.
module sphere_region_peak_evaluator_top #(
   parameter int GRID_CELLS = srpe_pkg::GRID_CELLS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  srpe_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output srpe_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [srpe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [srpe_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   srpe_pkg::cfg_type    cfg_ff, cfg_in;
   srpe_pkg::cmd_type    cmd;
   srpe_pkg::status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            srpe_pkg::CSR_SIZE_X:      cfg_in.size_x      = csr_wdata[srpe_pkg::SIZE_W-1:0];
            srpe_pkg::CSR_SIZE_Y:      cfg_in.size_y      = csr_wdata[srpe_pkg::SIZE_W-1:0];
            srpe_pkg::CSR_SIZE_Z:      cfg_in.size_z      = csr_wdata[srpe_pkg::SIZE_W-1:0];
            srpe_pkg::CSR_SPLIT_LEVEL: cfg_in.split_level = csr_wdata;
            srpe_pkg::CSR_DEPTH_LIMIT: cfg_in.depth_limit = csr_wdata[srpe_pkg::DEPTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_x      <= 6'd32;
         cfg_ff.size_y      <= 6'd32;
         cfg_ff.size_z      <= 6'd32;
         cfg_ff.split_level <= 16'hFFFF;
         cfg_ff.depth_limit <= 4'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   srpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   srpe_dp #(
      .GRID_CELLS (GRID_CELLS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // A write word leaves the block ready for the next word.
   ast_write_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.opcode == srpe_pkg::OP_WRITE) |=> req_ready)
      else $error("block not ready after a write word");

   // An evaluate word occupies the block.
   ast_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.opcode == srpe_pkg::OP_EVAL) |=> !req_ready)
      else $error("block ready straight after an evaluate word");

   // The split flag agrees with the peak and the split level.
   ast_split_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.wants_split || rsp_data.peak_pressure > cfg_ff.split_level))
      else $error("split flag set without a peak above the split level");

endmodule

// File: tb/sv/tb_sphere_region_peak_evaluator_top.sv
// Self-checking testbench for the sphere region peak evaluator with its own grid and box predictor.
import srpe_pkg::*;

class region_peak_board;
   bit [VALUE_W-1:0] grid [GRID_CELLS_DEF];
   cfg_type          cfg;
   rsp_type          pending_peaks [$];
   int unsigned      errors;
   int unsigned      writes;
   int unsigned      evaluates;
   int unsigned      results;
   int unsigned      splits;

   function new();
      cfg = '{6'd32, 6'd32, 6'd32, 16'hFFFF, 4'd4};
   endfunction

   function void note_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_SIZE_X:      cfg.size_x      = value[SIZE_W-1:0];
         CSR_SIZE_Y:      cfg.size_y      = value[SIZE_W-1:0];
         CSR_SIZE_Z:      cfg.size_z      = value[SIZE_W-1:0];
         CSR_SPLIT_LEVEL: cfg.split_level = value[VALUE_W-1:0];
         CSR_DEPTH_LIMIT: cfg.depth_limit = value[DEPTH_W-1:0];
         default: ;
      endcase
   endfunction

   // Inclusive voxel window of one axis; returns 0 when the window is empty.
   function bit axis_window(logic [15:0] c, logic [15:0] r, logic [SIZE_W-1:0] dim,
                            output int unsigned lo, output int unsigned hi);
      longint low_prod;
      longint high_prod;
      lo = 0;
      hi = 0;
      if (dim == 0) return 1'b0;
      low_prod  = (longint'(c) - longint'(r)) * longint'(dim);
      high_prod = (longint'(c) + longint'(r)) * longint'(dim);
      lo = (low_prod < 0) ? 0 : 32'(low_prod >>> 16);
      hi = 32'(high_prod >>> 16);
      if (hi > dim - 1) hi = dim - 1;
      return lo <= hi;
   endfunction

   function void note_word(req_type w);
      int unsigned x0, x1, y0, y1, z0, z1;
      int unsigned addr;
      int unsigned sx, sy;
      logic [VALUE_W-1:0] peak;
      rsp_type want;
      if (w.opcode == OP_WRITE) begin
         grid[w.cell_index] = w.cell_value;
         writes++;
         return;
      end
      evaluates++;
      peak = '0;
      sx = cfg.size_x;
      sy = cfg.size_y;
      if (axis_window(w.center_x, w.sphere_radius, cfg.size_x, x0, x1) &&
          axis_window(w.center_y, w.sphere_radius, cfg.size_y, y0, y1) &&
          axis_window(w.center_z, w.sphere_radius, cfg.size_z, z0, z1)) begin
         for (int unsigned z = z0; z <= z1; z++) begin
            for (int unsigned y = y0; y <= y1; y++) begin
               for (int unsigned x = x0; x <= x1; x++) begin
                  addr = x + y * sx + z * sx * sy;
                  if (addr < GRID_CELLS_DEF && grid[addr] > peak) peak = grid[addr];
               end
            end
         end
      end
      want.peak_pressure = peak;
      want.wants_split   = (peak > cfg.split_level) && (w.tree_depth < cfg.depth_limit);
      pending_peaks.insert(pending_peaks.size(), want);
   endfunction

   function void check_peak(rsp_type got);
      rsp_type want;
      if (pending_peaks.size() == 0) begin
         $error("unexpected result word: peak_pressure %0d wants_split %0d",
                got.peak_pressure, got.wants_split);
         errors++;
         return;
      end
      want = pending_peaks.pop_front();
      results++;
      if (got.wants_split === 1'b1) splits++;
      if (got.peak_pressure !== want.peak_pressure) begin
         $error("peak_pressure: expected %0d, actual %0d", want.peak_pressure, got.peak_pressure);
         errors++;
      end
      if (got.wants_split !== want.wants_split) begin
         $error("wants_split: expected %0d, actual %0d", want.wants_split, got.wants_split);
         errors++;
      end
   endfunction
endclass

module tb_sphere_region_peak_evaluator_top;

   localparam int unsigned QUIET_LIMIT = 200000;
   localparam int          RANDOM_PHASES = 12;
   localparam int          WORDS_PER_PHASE = 120;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   region_peak_board board = new();
   int unsigned      tx_idle_pct = 12;
   int unsigned      rx_idle_pct = 64;
   int unsigned      quiet_cycles = 0;
   int unsigned      drain_pauses = 0;
   int unsigned      settings_used = 1;

   sphere_region_peak_evaluator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("sphere_region_peak_evaluator_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) board.check_peak(rsp_data);
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   function automatic req_type write_word(logic [14:0] idx, logic [VALUE_W-1:0] value);
      req_type w;
      w.opcode        = OP_WRITE;
      w.cell_index    = idx;
      w.cell_value    = value;
      w.center_x      = 16'($urandom);
      w.center_y      = 16'($urandom);
      w.center_z      = 16'($urandom);
      w.sphere_radius = 16'($urandom);
      w.tree_depth    = 4'($urandom);
      return w;
   endfunction

   function automatic req_type eval_word(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                                         logic [15:0] r, logic [DEPTH_W-1:0] depth);
      req_type w;
      w.opcode        = OP_EVAL;
      w.cell_index    = 15'($urandom);
      w.cell_value    = 16'($urandom);
      w.center_x      = cx;
      w.center_y      = cy;
      w.center_z      = cz;
      w.sphere_radius = r;
      w.tree_depth    = depth;
      return w;
   endfunction

   function automatic logic [SIZE_W-1:0] random_size();
      if ($urandom_range(0, 3) == 0) return 6'($urandom_range(33, 63));
      return 6'($urandom_range(1, 32));
   endfunction

   function automatic cfg_type phase_settings(int k);
      cfg_type c;
      case (k)
         0: c = '{6'd4, 6'd4, 6'd4, 16'd0, 4'd15};
         1: c = '{6'd1, 6'd1, 6'd1, 16'hFFFF, 4'd0};
         2: c = '{6'd0, 6'd5, 6'd7, 16'd100, 4'd8};
         3: c = '{6'd63, 6'd63, 6'd63, 16'h8000, 4'd8};
         4: c = '{6'd32, 6'd32, 6'd32, 16'd1000, 4'd4};
         default: begin
            c.size_x      = random_size();
            c.size_y      = random_size();
            c.size_z      = random_size();
            c.split_level = 16'($urandom);
            c.depth_limit = 4'($urandom);
         end
      endcase
      return c;
   endfunction

   // Large boxes are kept rare so that a scan of one cell a cycle stays affordable.
   function automatic req_type random_word();
      int unsigned cells;
      int unsigned top;
      logic [15:0] r;
      cells = board.cfg.size_x;
      cells = cells * board.cfg.size_y * board.cfg.size_z;
      if ($urandom_range(0, 99) < 55) begin
         if (cells != 0 && $urandom_range(0, 9) < 7) begin
            top = (cells < GRID_CELLS_DEF) ? cells - 1 : GRID_CELLS_DEF - 1;
            return write_word(15'($urandom_range(0, top)), 16'($urandom));
         end
         return write_word(15'($urandom), 16'($urandom));
      end
      if (cells <= 512 && $urandom_range(0, 1) == 1) r = 16'($urandom);
      else if ($urandom_range(0, 15) == 0) r = 16'($urandom_range(0, 8191));
      else r = 16'($urandom_range(0, 2047));
      return eval_word(16'($urandom), 16'($urandom), 16'($urandom), r, 4'($urandom));
   endfunction

   task automatic send_word(input req_type w);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(0, 99) < tx_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_word(w);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_peaks.size() != 0) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.note_register(idx, value);
   endtask

   task automatic write_settings(input cfg_type c);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_put(CSR_SIZE_X, 16'(c.size_x));
      csr_put(CSR_SIZE_Y, 16'(c.size_y));
      csr_put(CSR_SIZE_Z, 16'(c.size_z));
      csr_put(CSR_SPLIT_LEVEL, c.split_level);
      csr_put(CSR_DEPTH_LIMIT, 16'(c.depth_limit));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_word(eval_word(16'd0, 16'd0, 16'd0, 16'd0, 4'd0));
      send_word(write_word(15'd0, 16'hFFFF));
      send_word(write_word(15'h7FFF, 16'h0001));
      send_word(write_word(15'd1057, 16'h8000));
      send_word(eval_word(16'd0, 16'd0, 16'd0, 16'd0, 4'd0));
      send_word(eval_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 4'd15));
      send_word(eval_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd3));
      send_word(eval_word(16'h8000, 16'h8000, 16'h8000, 16'h0800, 4'd1));
      send_word(write_word(15'd0, 16'h0000));
      send_word(eval_word(16'd2048, 16'd2048, 16'd2048, 16'd4096, 4'd2));
      send_word(write_word(15'd31, 16'h7FFF));
      send_word(eval_word(16'hFFFF, 16'd0, 16'd0, 16'd0, 4'd0));

      write_settings('{6'd32, 6'd32, 6'd32, 16'h7FFF, 4'd4});
      send_word(eval_word(16'd2048, 16'd2048, 16'd2048, 16'd4096, 4'd3));
      send_word(eval_word(16'd2048, 16'd2048, 16'd2048, 16'd4096, 4'd4));
      send_word(eval_word(16'hFFFF, 16'd0, 16'd0, 16'd0, 4'd0));
      send_word(write_word(15'd1057, 16'h0000));
      send_word(eval_word(16'd2048, 16'd2048, 16'd2048, 16'd4096, 4'd0));

      for (int k = 0; k < RANDOM_PHASES; k++) begin
         if (k < RANDOM_PHASES / 3) begin
            tx_idle_pct = 12;
            rx_idle_pct = 64;
         end else if (k < 2 * RANDOM_PHASES / 3) begin
            tx_idle_pct = 64;
            rx_idle_pct = 12;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         write_settings(phase_settings(k));
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if ($urandom_range(0, 59) == 0) begin
               wait_drained();
               drain_pauses++;
            end
            send_word(random_word());
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);

      $display("Covered %0d grid writes and %0d sphere evaluations under %0d register settings,",
               board.writes, board.evaluates, settings_used);
      $display("with %0d results checked, %0d split requests and %0d drain pauses.",
               board.results, board.splits, drain_pauses);
      if (board.errors == 0 && board.pending_peaks.size() == 0) begin
         $display("sphere_region_peak_evaluator_top: match");
      end else begin
         $display("sphere_region_peak_evaluator_top: mismatch");
      end
      $finish;
   end

endmodule

// File: sphere_region_peak_evaluator_top.f
src/srpe_pkg.sv
src/srpe_ctrl.sv
src/srpe_dp.sv
src/sphere_region_peak_evaluator_top.sv
tb/sv/tb_sphere_region_peak_evaluator_top.sv
